@@ rtl/core/idal_pkg.sv @@
// Package for the identifier allocator: sizes, request codes and the sequencer state type.
// It has no dependencies. The top level and the configuration register block use it.
package idal_pkg;

  localparam int CAPACITY = 1024;
  localparam int ID_W     = $clog2(CAPACITY);
  localparam int CNT_W    = ID_W + 1;
  localparam int FUNC_W   = 2;
  localparam int POOL_W   = 11;
  localparam int IN_W     = 16;
  localparam int OUT_W    = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GET     = 2'd0,
    FUNC_CHECK   = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  // Register word index of max_ids
  localparam logic REG_MAX_IDS = 1'b0;

endpackage

@@ rtl/core/idal_cfg.sv @@
// APB register block of the identifier allocator: holds the max_ids pool size.
// It depends on idal_pkg.
module idal_cfg import idal_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [APB_AW-1:0]    cfg_paddr,
  input  logic [APB_DW-1:0]    cfg_pwdata,
  output logic [APB_DW-1:0]    cfg_prdata,
  output logic                 cfg_pready,
  output logic [POOL_W-1:0]    max_ids
);

  logic [POOL_W-1:0] max_ids_r;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
               & (cfg_paddr[2] == REG_MAX_IDS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_ids_r <= POOL_W'(CAPACITY);
    end else if (wr_en) begin
      max_ids_r <= cfg_pwdata[POOL_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_MAX_IDS) begin
      cfg_prdata = {{(APB_DW-POOL_W){1'b0}}, max_ids_r};
    end
  end

  assign max_ids = max_ids_r;

endmodule

@@ rtl/core/id_allocator_lifo_recycle.sv @@
// Top level of the identifier allocator with a last-in-first-out recycle stack.
// It depends on idal_pkg and instantiates idal_cfg.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------
//  in_     | slave     | in_tvalid / in_tready  | in_tdata: func[1:0], id_number[11:2]
//  out_    | master    | out_tvalid / out_tready| out_tdata: ok[0], granted_id[10:1]
//  cfg_    | APB slave | psel/penable, pready=1 | max_ids at byte address 0
//
// A request is handled in the states S_IDLE and S_EXEC: S_IDLE reads the stack top and the
// free flag of the id from their synchronous memories as the request is taken, S_EXEC
// modifies and writes them back.
// Reset is synchronous and needs no clearing pass: flags of ids at or above the fresh
// counter read as free, every lower flag has already been written.
// A result waits in the output register; a new request is taken meanwhile and stalls
// in its write-back cycle only while the output register is still occupied.
module id_allocator_lifo_recycle import idal_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // func[1:0], id_number[11:2], zero[15:12]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // ok[0], granted_id[10:1], zero[15:11]
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [APB_AW-1:0]    cfg_paddr,
  input  logic [APB_DW-1:0]    cfg_pwdata,
  output logic [APB_DW-1:0]    cfg_prdata,
  output logic                 cfg_pready
);

  logic [POOL_W-1:0] max_ids;
  logic [CNT_W-1:0]  pool_size;

  idal_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .max_ids    (max_ids)
  );

  // Saturate the pool size to the capacity
  assign pool_size = (CNT_W'(max_ids) > CAP_CNT) ? CAP_CNT : CNT_W'(max_ids);

  // Memories
  logic [ID_W-1:0] stack_mem [CAPACITY];
  logic            flag_mem  [CAPACITY];
  logic [ID_W-1:0] stack_q;
  logic            flag_q;

  // Control and request registers
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] fresh_next_r, fresh_next_nxt;
  logic [CNT_W-1:0] stack_count_r, stack_count_nxt;
  logic [FUNC_W-1:0] func_r;
  logic [ID_W-1:0]  id_r;
  logic             out_valid_r, out_valid_nxt;
  logic             ok_r, ok_nxt;
  logic [ID_W-1:0]  grant_r, grant_nxt;

  logic             in_fire;
  logic             exec_fire;
  logic             id_free;
  logic             id_in_range;
  logic             stack_we;
  logic [ID_W-1:0]  stack_waddr;
  logic             flag_we;
  logic [ID_W-1:0]  flag_waddr;
  logic             flag_wdata;
  logic [ID_W-1:0]  stack_raddr;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid & in_tready;
  assign exec_fire = (state_r == S_EXEC) & (~out_valid_r | out_tready);

  // Read the current stack top; garbage when empty, then unused
  assign stack_raddr = ID_W'(stack_count_r - CNT_W'(1));

  // Read both memories as the request is taken
  always_ff @(posedge clk) begin
    if (in_fire) begin
      stack_q <= stack_mem[stack_raddr];
      flag_q  <= flag_mem[in_tdata[FUNC_W +: ID_W]];
      func_r  <= in_tdata[FUNC_W-1:0];
      id_r    <= in_tdata[FUNC_W +: ID_W];
    end
  end

  // Write back in the execute cycle
  always_ff @(posedge clk) begin
    if (stack_we) begin
      stack_mem[stack_waddr] <= id_r;
    end
    if (flag_we) begin
      flag_mem[flag_waddr] <= flag_wdata;
    end
  end

  // Ids never issued are free whatever the flag memory holds
  assign id_free     = (CNT_W'(id_r) >= fresh_next_r) ? 1'b1 : flag_q;
  assign id_in_range = (CNT_W'(id_r) < pool_size);

  always_comb begin
    state_nxt       = state_r;
    fresh_next_nxt  = fresh_next_r;
    stack_count_nxt = stack_count_r;
    out_valid_nxt   = out_valid_r & ~out_tready;
    ok_nxt          = ok_r;
    grant_nxt       = grant_r;
    stack_we        = 1'b0;
    stack_waddr     = stack_count_r[ID_W-1:0];
    flag_we         = 1'b0;
    flag_waddr      = id_r;
    flag_wdata      = 1'b1;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_fire) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          ok_nxt        = 1'b0;
          grant_nxt     = '0;
          case (func_r)
            FUNC_GET: begin
              if (stack_count_r != '0) begin
                // Pop the most recently released id
                stack_count_nxt = stack_count_r - CNT_W'(1);
                flag_we         = 1'b1;
                flag_waddr      = stack_q;
                flag_wdata      = 1'b0;
                ok_nxt          = 1'b1;
                grant_nxt       = stack_q;
              end else if (fresh_next_r < pool_size) begin
                // Issue the next fresh id
                fresh_next_nxt = fresh_next_r + CNT_W'(1);
                flag_we        = 1'b1;
                flag_waddr     = fresh_next_r[ID_W-1:0];
                flag_wdata     = 1'b0;
                ok_nxt         = 1'b1;
                grant_nxt      = fresh_next_r[ID_W-1:0];
              end
            end
            FUNC_CHECK: begin
              ok_nxt = id_in_range & id_free;
            end
            FUNC_RELEASE: begin
              if (id_in_range && !id_free && stack_count_r < CAP_CNT) begin
                // Push the id and mark it free
                stack_we        = 1'b1;
                stack_count_nxt = stack_count_r + CNT_W'(1);
                flag_we         = 1'b1;
                flag_wdata      = 1'b1;
                ok_nxt          = 1'b1;
              end
            end
            default: begin
              ok_nxt = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fresh_next_r  <= '0;
      stack_count_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      fresh_next_r  <= fresh_next_nxt;
      stack_count_r <= stack_count_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    grant_r <= grant_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W-ID_W-1){1'b0}}, grant_r, ok_r};

endmodule

@@ verif/tb.sv @@
// Self-checking bench for the identifier allocator with a LIFO recycle stack.
// Depends on idal_pkg and id_allocator_lifo_recycle; drives both streams and the APB port.
`timescale 1ns / 1ps

module tb;
  import idal_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off

  typedef struct packed {
    logic            ok;
    logic [ID_W-1:0] grant;
  } answer_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata    = '0;  // func[1:0], id_number[11:2], zero[15:12]
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_W-1:0]  out_tdata;         // ok[0], granted_id[10:1], zero[15:11]
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [APB_AW-1:0] cfg_paddr   = '0;
  logic [APB_DW-1:0] cfg_pwdata  = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  id_allocator_lifo_recycle uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Allocator mirror: pool register, fresh counter, recycle stack, free flags.
  // ---------------------------------------------------------------------------
  logic [POOL_W-1:0] pool_reg   = POOL_W'(1024);
  logic [CNT_W-1:0]  fresh_ptr  = '0;
  logic [CNT_W-1:0]  stack_depth = '0;
  logic [ID_W-1:0]   recycle_mem [CAPACITY];
  bit                free_map    [CAPACITY];
  logic [ID_W-1:0]   issued_ids [$];     // ids currently handed out, for release picks
  answer_t           pending_answers [$];

  int  errors    = 0;
  bit  in_gaps   = 1'b1;   // sender idles in random bursts
  bit  out_gaps  = 1'b1;   // receiver stalls in random bursts
  bit  hold_req  = 1'b0;   // ask the receiver for one long hold-off

  initial begin
    foreach (free_map[i]) free_map[i] = 1'b1;
  end

  // Apply one request to the mirror and return the answer it must produce.
  function automatic answer_t model_request(func_t f, logic [ID_W-1:0] id);
    answer_t          a;
    logic [CNT_W-1:0] size;
    a    = '0;
    // pool size saturates at the stack capacity
    size = (pool_reg > CAP_CNT) ? CAP_CNT : pool_reg[CNT_W-1:0];
    case (f)
      FUNC_GET: begin
        if (stack_depth != '0) begin
          // recycled ids win, even ones above a shrunken pool
          stack_depth = stack_depth - CNT_W'(1);
          a.grant = recycle_mem[stack_depth[ID_W-1:0]];
          a.ok    = 1'b1;
        end else if (fresh_ptr < size) begin
          a.grant   = fresh_ptr[ID_W-1:0];
          a.ok      = 1'b1;
          fresh_ptr = fresh_ptr + CNT_W'(1);
        end
        if (a.ok) begin
          free_map[a.grant] = 1'b0;
          issued_ids.push_back(a.grant);
        end
      end
      FUNC_CHECK: begin
        a.ok = ({1'b0, id} < size) && free_map[id];
      end
      FUNC_RELEASE: begin
        // ignore out-of-range ids, free ids and a full stack
        if (({1'b0, id} < size) && !free_map[id] && (stack_depth < CAP_CNT)) begin
          recycle_mem[stack_depth[ID_W-1:0]] = id;
          stack_depth  = stack_depth + CNT_W'(1);
          free_map[id] = 1'b1;
          a.ok         = 1'b1;
          for (int i = 0; i < issued_ids.size(); i++) begin
            if (issued_ids[i] == id) begin
              issued_ids.delete(i);
              break;
            end
          end
        end
      end
      default: ;  // unused code: no state change, all-zero answer
    endcase
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Request sender. Always returns at the rising edge where the request was
  // taken; tvalid stays high so a back-to-back request needs no second write.
  // ---------------------------------------------------------------------------
  task automatic send_request(func_t f, logic [ID_W-1:0] id);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, id, f};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_answers.push_back(model_request(f, id));
  endtask

  // Drop tvalid and hold until every answer is back, plus pipeline slack.
  task automatic drain_requests();
    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write max_ids while idle, then read it back in the same APB burst.
  task automatic write_pool_size(logic [POOL_W-1:0] val);
    drain_requests();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_AW'({REG_MAX_IDS, 2'b00});
    cfg_pwdata  <= APB_DW'(val);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    pool_reg = val;
    // turn the access into a read setup of the same register
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== APB_DW'(val)) begin
      $error("max_ids readback: expected %0d, actual %0d", val, cfg_prdata);
      errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // One random request, biased toward releasing ids that are really held.
  task automatic send_random_request();
    int              pick;
    logic [ID_W-1:0] id;
    pick = $urandom_range(0, 99);
    id   = ID_W'($urandom);
    if (pick < 45) begin
      send_request(FUNC_GET, id);
    end else if (pick < 80) begin
      if (issued_ids.size() != 0 && $urandom_range(0, 4) != 0)
        id = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
      send_request(FUNC_RELEASE, id);
    end else if (pick < 95) begin
      // mostly probe inside the pool, sometimes anywhere
      if (pool_reg != '0 && $urandom_range(0, 2) != 0)
        id = ID_W'($urandom_range(0, (pool_reg > CAP_CNT ? CAPACITY : pool_reg) - 1));
      send_request(FUNC_CHECK, id);
    end else begin
      send_request(FUNC_NONE, id);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, or one long hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_tready <= 1'b1;
        hold_req = 1'b0;
      end else if (out_gaps && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Compare each delivered answer with the oldest predicted one.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        $error("answer without a pending request: ok %0b granted_id %0d",
               out_tdata[0], out_tdata[ID_W:1]);
        errors++;
      end else begin
        if (out_tdata[0] !== pending_answers[0].ok) begin
          $error("ok: expected %0b, actual %0b", pending_answers[0].ok, out_tdata[0]);
          errors++;
        end
        if (out_tdata[ID_W:1] !== pending_answers[0].grant) begin
          $error("granted_id: expected %0d, actual %0d",
                 pending_answers[0].grant, out_tdata[ID_W:1]);
          errors++;
        end
        void'(pending_answers.pop_front());
      end
    end
  end

  // Stop the run if no handshake of any kind happens for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("id_allocator_lifo_recycle: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh issue, LIFO reuse, double release, edge ids, unused code.
  task automatic test_lifo_basics();
    send_request(FUNC_CHECK,   ID_W'(0));
    send_request(FUNC_CHECK,   ID_W'(1023));
    send_request(FUNC_GET,     ID_W'(1023));
    send_request(FUNC_GET,     ID_W'(0));
    send_request(FUNC_GET,     ID_W'(0));
    send_request(FUNC_CHECK,   ID_W'(1));
    send_request(FUNC_RELEASE, ID_W'(1023));  // free id: ignored
    send_request(FUNC_RELEASE, ID_W'(1));
    send_request(FUNC_RELEASE, ID_W'(2));
    send_request(FUNC_RELEASE, ID_W'(2));     // second release: ignored
    send_request(FUNC_GET,     ID_W'(0));     // last released comes back first
    send_request(FUNC_GET,     ID_W'(0));
    send_request(FUNC_GET,     ID_W'(0));     // stack empty again: fresh id
    send_request(FUNC_NONE,    ID_W'(1023));
    send_request(FUNC_RELEASE, ID_W'(0));
    send_request(FUNC_CHECK,   ID_W'(0));
  endtask

  // Shrink the pool with ids on the stack that are at or above the new size.
  task automatic test_pool_shrink();
    send_request(FUNC_RELEASE, ID_W'(3));
    send_request(FUNC_RELEASE, ID_W'(2));
    write_pool_size(POOL_W'(2));
    send_request(FUNC_GET,     ID_W'(0));
    send_request(FUNC_GET,     ID_W'(0));
    send_request(FUNC_GET,     ID_W'(0));
    send_request(FUNC_GET,     ID_W'(0));     // exhausted
    send_request(FUNC_CHECK,   ID_W'(3));     // out of range
    send_request(FUNC_RELEASE, ID_W'(3));     // out of range: ignored
    send_request(FUNC_RELEASE, ID_W'(1));
  endtask

  // Empty pool, then sizes above capacity that saturate.
  task automatic test_pool_limits();
    write_pool_size(POOL_W'(0));
    send_request(FUNC_GET,     ID_W'(0));
    send_request(FUNC_CHECK,   ID_W'(1));
    send_request(FUNC_RELEASE, ID_W'(0));
    write_pool_size(POOL_W'(2047));
    send_request(FUNC_CHECK,   ID_W'(1023));
    send_request(FUNC_GET,     ID_W'(0));
    write_pool_size(POOL_W'(1025));
    send_request(FUNC_RELEASE, ID_W'(1023));
  endtask

  // Random traffic over a series of pool sizes, including exhaustion.
  task automatic test_random_pools();
    logic [POOL_W-1:0] sizes [8];
    sizes = '{POOL_W'(16), POOL_W'(7), POOL_W'(1), POOL_W'(2), POOL_W'(64),
              POOL_W'(1023), POOL_W'(2047), POOL_W'($urandom_range(0, 2047))};
    foreach (sizes[p]) begin
      write_pool_size(sizes[p]);
      repeat (116) send_random_request();
    end
  endtask

  // Long receiver hold-off while requests keep coming, then a full drain.
  task automatic test_backpressure();
    write_pool_size(POOL_W'(32));
    hold_req = 1'b1;
    repeat (40) send_random_request();
    drain_requests();
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_full_rate();
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    write_pool_size(POOL_W'(1024));
    repeat (150) send_random_request();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_lifo_basics();
    test_pool_shrink();
    test_pool_limits();
    test_random_pools();
    test_backpressure();
    test_full_rate();

    drain_requests();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("id_allocator_lifo_recycle: match");
    end else begin
      $display("id_allocator_lifo_recycle: mismatch");
    end
    $finish;
  end

endmodule
